// File: sv/pbrd_pkg.sv
package pbrd_pkg;

   // Width of the running decoded-length counter.
   localparam int COUNT_BITS = 16;
   // Width that holds the counter plus one group size without wrapping.
   localparam int CMP_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

   localparam logic [15:0] CAP_RESET = 16'hFFFF;
   localparam logic [7:0]  HDR_END   = 8'h80;
   localparam logic [8:0]  RUN_BASE  = 9'd257;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LITERAL,
      PH_RUN,
      PH_STOPPED
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_TRUNC,
      ST_OVER,
      ST_NOROOM
   } status_type;

   typedef struct packed {
      logic        data_valid;
      logic [7:0]  out_byte;
      logic [7:0]  repeat_count;
      logic        done_res;
      status_type  status;
      logic [15:0] total_len;
   } result_type;

endpackage

// File: sv/pbrd_req_if.sv
interface pbrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

// File: sv/pbrd_rsp_if.sv
interface pbrd_rsp_if;
   logic        valid;
   logic        ready;
   logic        data_valid;
   logic [7:0]  out_byte;
   logic [7:0]  repeat_count;
   logic        done_res;
   logic [1:0]  status;
   logic [15:0] total_len;

   modport source (
      output valid, output data_valid, output out_byte, output repeat_count,
      output done_res, output status, output total_len, input ready
   );
   modport sink (
      input valid, input data_valid, input out_byte, input repeat_count,
      input done_res, input status, input total_len, output ready
   );
endinterface

// File: sv/pbrd_csr_if.sv
interface pbrd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_capacity;

   modport source (output valid, output out_capacity, input ready);
   modport sink (input valid, input out_capacity, output ready);
endinterface

// File: sv/packbits_run_decoder_core.sv
// Results are registered in the result register, or the skid register while
// it is full. Throughput: one packed byte per cycle unless the skid register
// is full; the two-entry output buffer keeps req open while one result waits.
// Reset is synchronous and active high: the decoder returns to expecting a
// header with zero count and ok status, out_capacity returns to 65535.
module packbits_run_decoder_core (
   input logic         clock,
   input logic         reset,
   pbrd_req_if.sink    req_chan,
   pbrd_rsp_if.source  rsp_chan,
   pbrd_csr_if.sink    csr_chan
);
   import pbrd_pkg::*;

   logic [15:0]           capacity_ff;
   phase_type             phase_ff, phase_in;
   logic [7:0]            literals_left_ff, literals_left_in;
   logic [7:0]            run_length_ff, run_length_in;
   logic [COUNT_BITS-1:0] out_count_ff, out_count_in;
   status_type            error_ff, error_in;

   result_type            main_ff, skid_ff;
   logic                  main_valid_ff, skid_valid_ff;

   result_type            res;
   logic                  has_result;
   logic                  accept, pop, push;
   logic [7:0]            in_b;
   logic                  in_last;
   logic                  is_run;
   logic [7:0]            group_cnt;
   logic                  overflow;

   assign accept  = req_chan.valid && req_chan.ready;
   assign in_b    = req_chan.in_byte;
   assign in_last = req_chan.last_byte;

   // Header decode: literal groups hold b+1 bytes, runs 257-b copies.
   assign is_run    = in_b[7];
   assign group_cnt = is_run ? 8'(RUN_BASE - {1'b0, in_b}) : (in_b + 8'd1);
   assign overflow  = (CMP_BITS'(out_count_ff) + CMP_BITS'(group_cnt))
                      > CMP_BITS'(capacity_ff);

   // Next state
   always_comb begin
      phase_in         = phase_ff;
      literals_left_in = literals_left_ff;
      run_length_in    = run_length_ff;
      out_count_in     = out_count_ff;
      error_in         = error_ff;
      case (phase_ff)
         PH_HEADER: begin
            if (capacity_ff == 16'd0) begin
               error_in = ST_NOROOM;
               phase_in = PH_STOPPED;
            end else if (in_b == HDR_END) begin
               phase_in = PH_STOPPED;
            end else if (in_last) begin
               error_in = ST_TRUNC;
               phase_in = PH_STOPPED;
            end else if (overflow) begin
               error_in = ST_OVER;
               phase_in = PH_STOPPED;
            end else if (!is_run) begin
               literals_left_in = group_cnt;
               phase_in         = PH_LITERAL;
            end else begin
               run_length_in = group_cnt;
               phase_in      = PH_RUN;
            end
         end
         PH_LITERAL: begin
            out_count_in     = out_count_ff + COUNT_BITS'(1);
            literals_left_in = literals_left_ff - 8'd1;
            if (literals_left_in == 8'd0) begin
               phase_in = PH_HEADER;
            end else if (in_last) begin
               error_in = ST_TRUNC;
               phase_in = PH_STOPPED;
            end
         end
         PH_RUN: begin
            out_count_in = out_count_ff + COUNT_BITS'(run_length_ff);
            phase_in     = PH_HEADER;
         end
         default: begin
         end
      endcase
   end

   // Result for the item at the input
   always_comb begin
      res.data_valid   = (phase_ff == PH_LITERAL) || (phase_ff == PH_RUN);
      res.out_byte     = res.data_valid ? in_b : 8'd0;
      case (phase_ff)
         PH_LITERAL: res.repeat_count = 8'd1;
         PH_RUN:     res.repeat_count = run_length_ff;
         default:    res.repeat_count = 8'd0;
      endcase
      res.done_res     = in_last;
      res.status       = in_last ? error_in : ST_OK;
      res.total_len    = 16'(out_count_in);
      has_result       = res.data_valid || in_last;
   end

   // Decoder state; the final byte of a stream starts the next one afresh.
   always_ff @(posedge clock) begin
      if (reset || (accept && in_last)) begin
         phase_ff         <= PH_HEADER;
         literals_left_ff <= 8'd0;
         run_length_ff    <= 8'd0;
         out_count_ff     <= '0;
         error_ff         <= ST_OK;
      end else if (accept) begin
         phase_ff         <= phase_in;
         literals_left_ff <= literals_left_in;
         run_length_ff    <= run_length_in;
         out_count_ff     <= out_count_in;
         error_ff         <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         capacity_ff <= csr_chan.out_capacity;
      end
   end

   // Output buffer: the skid entry is always younger than the main entry.
   assign pop  = main_valid_ff && rsp_chan.ready;
   assign push = accept && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (!main_valid_ff || pop) begin
         main_valid_ff <= push;
         if (push) begin
            main_ff <= res;
         end
      end else if (push) begin
         skid_ff       <= res;
         skid_valid_ff <= 1'b1;
      end
   end

   assign req_chan.ready        = !skid_valid_ff;
   assign csr_chan.ready        = 1'b1;
   assign rsp_chan.valid        = main_valid_ff;
   assign rsp_chan.data_valid   = main_ff.data_valid;
   assign rsp_chan.out_byte     = main_ff.out_byte;
   assign rsp_chan.repeat_count = main_ff.repeat_count;
   assign rsp_chan.done_res     = main_ff.done_res;
   assign rsp_chan.status       = main_ff.status;
   assign rsp_chan.total_len    = main_ff.total_len;

   // A waiting younger result never exists without an older one ahead of it.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry valid while result register empty");

   // Once stopped, bytes produce no decoded data.
   a_stopped_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_STOPPED) |-> !res.data_valid)
      else $error("decoded data emitted while stopped");

   // The final byte of a stream leaves the decoder ready for a new header.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && in_last) |=> (phase_ff == PH_HEADER && out_count_ff == '0
                               && error_ff == ST_OK))
      else $error("stream state not cleared after final byte");

   // Decoded data always carries a nonzero repeat count.
   a_repeat_nonzero: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && main_ff.data_valid) |-> main_ff.repeat_count != 8'd0)
      else $error("decoded data with zero repeat count");

   // A result that is not the final one always carries data.
   a_no_empty_result: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && !main_ff.done_res) |-> main_ff.data_valid)
      else $error("empty result issued");

endmodule

// File: dv/packbits_run_decoder_core_tb.sv
`timescale 1ns / 1ps

module packbits_run_decoder_core_tb;
   import pbrd_pkg::*;

   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } packed_byte_type;

   logic clock;
   logic reset;

   pbrd_req_if req_bus ();
   pbrd_rsp_if rsp_bus ();
   pbrd_csr_if csr_bus ();

   packbits_run_decoder_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Packed bytes waiting to be sent, and decoded results still owed by the block.
   packed_byte_type send_q[$];
   result_type      decoded_q[$];

   // Shadow of the decoder state and of its capacity register.
   phase_type  dec_phase;
   status_type dec_status;
   logic [7:0]  lits_left;
   logic [7:0]  run_len;
   logic [15:0] decoded_count;
   logic [15:0] cap_shadow;

   int unsigned queued_count;
   int unsigned accepted_count;
   int unsigned error_count;
   int unsigned cycle_count;
   int src_gap;
   int snk_stall;
   bit src_steady;
   bit snk_steady;
   packed_byte_type next_byte;
   result_type      predicted;
   result_type      want;
   result_type      got;

   always #5 clock = ~clock;

   function automatic void restart_stream();
      dec_phase     = PH_HEADER;
      dec_status    = ST_OK;
      lits_left     = '0;
      run_len       = '0;
      decoded_count = '0;
   endfunction

   // Advances the shadow decoder by one packed byte; returns 1 when the byte
   // produces a result, which is then placed in res.
   function automatic bit decode_packed_byte(input logic [7:0] b, input logic last,
                                             output result_type res);
      logic [8:0]  group_len;
      logic [16:0] needed;
      res        = '0;
      res.status = ST_OK;
      case (dec_phase)
         PH_HEADER: begin
            group_len = b[7] ? (RUN_BASE - {1'b0, b}) : ({1'b0, b} + 9'd1);
            needed    = {1'b0, decoded_count} + {8'b0, group_len};
            if (cap_shadow == '0) begin
               dec_status = ST_NOROOM;
               dec_phase  = PH_STOPPED;
            end else if (b == HDR_END) begin
               dec_phase = PH_STOPPED;
            end else if (last) begin
               dec_status = ST_TRUNC;
               dec_phase  = PH_STOPPED;
            end else if (needed > {1'b0, cap_shadow}) begin
               dec_status = ST_OVER;
               dec_phase  = PH_STOPPED;
            end else if (!b[7]) begin
               lits_left = group_len[7:0];
               dec_phase = PH_LITERAL;
            end else begin
               run_len   = group_len[7:0];
               dec_phase = PH_RUN;
            end
         end
         PH_LITERAL: begin
            res.data_valid   = 1'b1;
            res.out_byte     = b;
            res.repeat_count = 8'd1;
            decoded_count    = decoded_count + 16'd1;
            lits_left        = lits_left - 8'd1;
            if (lits_left == '0) begin
               dec_phase = PH_HEADER;
            end else if (last) begin
               dec_status = ST_TRUNC;
               dec_phase  = PH_STOPPED;
            end
         end
         PH_RUN: begin
            res.data_valid   = 1'b1;
            res.out_byte     = b;
            res.repeat_count = run_len;
            decoded_count    = decoded_count + {8'b0, run_len};
            dec_phase        = PH_HEADER;
         end
         default: begin
         end
      endcase
      if (!res.data_valid && !last) return 1'b0;
      res.done_res  = last;
      res.status    = last ? dec_status : ST_OK;
      res.total_len = decoded_count;
      if (last) restart_stream();
      return 1'b1;
   endfunction

   // Sender: one item on req per handshake, with a random gap after each unless src_steady.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("packbits_run_decoder_core_tb failed");
         $finish;
      end else if (reset) begin
         req_bus.valid <= 1'b0;
         src_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (decode_packed_byte(req_bus.in_byte, req_bus.last_byte, predicted))
               decoded_q.push_back(predicted);
            accepted_count++;
            src_gap = src_steady ? 0 : $urandom_range(0, 9);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_bus.valid <= 1'b0;
            end else if (send_q.size() != 0) begin
               next_byte = send_q.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.in_byte   <= next_byte.value;
               req_bus.last_byte <= next_byte.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks every result against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         snk_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.data_valid   = rsp_bus.data_valid;
            got.out_byte     = rsp_bus.out_byte;
            got.repeat_count = rsp_bus.repeat_count;
            got.done_res     = rsp_bus.done_res;
            got.status       = status_type'(rsp_bus.status);
            got.total_len    = rsp_bus.total_len;
            // Fields are shown in the order data_valid, out_byte, repeat_count,
            // done_res, status, total_len.
            if (decoded_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected item, actual %0d %h %0d %0d %0d %0d",
                        $time, got.data_valid, got.out_byte, got.repeat_count,
                        got.done_res, got.status, got.total_len);
            end else begin
               want = decoded_q.pop_front();
               if (got !== want) begin
                  error_count++;
                  $display("%0t: expected %0d %h %0d %0d %0d %0d, actual %0d %h %0d %0d %0d %0d",
                           $time, want.data_valid, want.out_byte, want.repeat_count,
                           want.done_res, want.status, want.total_len,
                           got.data_valid, got.out_byte, got.repeat_count,
                           got.done_res, got.status, got.total_len);
               end
            end
            snk_stall = snk_steady ? 0 : $urandom_range(0, 9);
         end
         if (snk_stall > 0) begin
            snk_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic push_byte(input logic [7:0] value, input logic last);
      packed_byte_type item;
      item.value = value;
      item.last  = last;
      send_q.push_back(item);
      queued_count++;
   endtask

   // Waits until every sent item is handled and every result is back.
   task automatic wait_idle();
      while (accepted_count != queued_count || decoded_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      csr_bus.out_capacity <= value;
      csr_bus.valid        <= 1'b1;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      cap_shadow = value;
      csr_bus.valid <= 1'b0;
   endtask

   // A stream of literal and run groups with random content. Most streams end
   // cleanly; some end on an end marker, some are cut short, and the last one
   // of a phase may be left open so the next setting lands mid-stream.
   task automatic add_stream(input bit may_leave_open);
      logic [7:0] body[$];
      int n;
      int ending;
      int cut;
      bit close;
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 9))
               0: n = 128;
               1, 2: n = $urandom_range(1, 128);
               default: n = $urandom_range(1, 8);
            endcase
            body.push_back(8'(n - 1));
            repeat (n) body.push_back(8'($urandom));
         end else begin
            n = $urandom_range(2, 128);
            body.push_back(8'(257 - n));
            body.push_back(8'($urandom));
         end
      end
      close  = 1'b1;
      ending = $urandom_range(0, 9);
      case (ending)
         5: body.push_back(HDR_END);
         6: begin
            body.push_back(HDR_END);
            repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
         end
         7, 8: begin
            cut = $urandom_range(1, body.size());
            while (body.size() > cut) void'(body.pop_back());
         end
         9: close = !may_leave_open;
         default: begin
         end
      endcase
      foreach (body[i]) push_byte(body[i], close && (i == body.size() - 1));
   endtask

   task automatic add_noise();
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom), $urandom_range(0, 5) == 0);
      push_byte(8'($urandom), 1'b1);
   endtask

   initial begin
      int unsigned phase_start;
      int unsigned phase_items;
      clock                = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.in_byte      = '0;
      req_bus.last_byte    = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.out_capacity = '0;
      cap_shadow           = CAP_RESET;
      restart_stream();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Default capacity: single literal, longest run, shortest run, end marker
      // followed by ignored bytes, truncated literal group, header on the last
      // byte, and an empty stream.
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h81, 1'b0);
      push_byte(8'hA5, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(HDR_END, 1'b0);
      push_byte(8'h5C, 1'b0);
      push_byte(8'hC3, 1'b1);
      push_byte(8'h02, 1'b0);
      push_byte(8'h11, 1'b0);
      push_byte(8'h22, 1'b1);
      push_byte(8'hFE, 1'b1);
      push_byte(HDR_END, 1'b1);
      wait_idle();

      // No room is reported even ahead of the end marker.
      write_capacity(16'h0000);
      push_byte(HDR_END, 1'b1);
      wait_idle();

      // Overflow keeps the literals already out; overflow beats a later
      // truncation.
      write_capacity(16'd5);
      push_byte(8'h02, 1'b0);
      push_byte(8'h7E, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'hFE, 1'b0);
      push_byte(8'h44, 1'b1);
      push_byte(8'h05, 1'b0);
      push_byte(8'h66, 1'b1);
      push_byte(8'h01, 1'b0);
      push_byte(8'h10, 1'b0);
      wait_idle();

      // The new capacity only counts from the next header onward.
      write_capacity(16'd1);
      push_byte(8'h20, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h30, 1'b1);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: write_capacity(16'hFFFF);
            1: write_capacity(16'($urandom_range(1, 300)));
            2: write_capacity(16'($urandom));
            3: write_capacity(16'h0000);
            4: write_capacity(16'($urandom_range(1, 40)));
            default: write_capacity(16'($urandom_range(100, 1000)));
         endcase
         src_steady  = (p == 1) || (p == 4);
         snk_steady  = (p == 2) || (p == 4);
         phase_items = (p == 3) ? 10 : 25;
         phase_start = queued_count;
         while (queued_count - phase_start < phase_items) begin
            if ($urandom_range(0, 4) == 0)
               add_noise();
            else
               add_stream(1'b0);
         end
         add_stream(1'b1);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("packbits_run_decoder_core_tb passed");
      end else begin
         $display("packbits_run_decoder_core_tb failed");
      end
      $finish;
   end

endmodule
